[src/assert_macros.svh]
// Assertion macros shared by the timer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[src/tmr_pkg.sv]
// Types, constants and helper functions of the cascadable four-channel timer.
package tmr_pkg;

    localparam int COUNT_W    = 16;
    localparam int PRESCALE_W = 10;
    localparam int IRQ_W      = 4;
    localparam int CHAN_W     = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam int CTRL_CASCADE_BIT = 2;
    localparam int CTRL_IRQ_BIT     = 6;
    localparam int CTRL_ENABLE_BIT  = 7;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_RELOAD = 2'd1,
        KIND_CTRL   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PRESCALE_1    = 2'd0,
        PRESCALE_64   = 2'd1,
        PRESCALE_256  = 2'd2,
        PRESCALE_1024 = 2'd3
    } prescale_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] read_data;
        logic [IRQ_W-1:0]   irq_flags;
    } result_t;

    typedef struct packed {
        logic               tick;
        logic               write_reload;
        logic               write_ctrl;
        logic [COUNT_W-1:0] value;
    } chan_cmd_t;

    function automatic logic [PRESCALE_W-1:0] prescale_limit(input prescale_t sel);
        logic [PRESCALE_W-1:0] lim;
        case (sel)
            PRESCALE_1:    lim = 10'd0;
            PRESCALE_64:   lim = 10'd63;
            PRESCALE_256:  lim = 10'd255;
            PRESCALE_1024: lim = 10'd1023;
            default:       lim = 10'd1023;
        endcase
        return lim;
    endfunction

endpackage

[src/cascadable_four_channel_timer.sv]
// Top level of the cascadable four-channel timer: item register, channels, result register.
// Takes one transaction per clock cycle on the item channel unless the result side stalls,
// and returns exactly one result transaction for each, via the item and result registers.
// The input register feeds a single pass of logic in which a tick is offered to all channels and
// an overflow carry ripples through the whole cascade chain within that cycle; the result
// register holds read data and the per-channel interrupt flags until taken, while the next
// item is already being accepted. Channels at or above NUM_CHANNELS ignore writes and read
// as zero; interrupt flags exist for the first four channels only.
`include "assert_macros.svh"

module cascadable_four_channel_timer #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tmr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output tmr_pkg::result_t result
);

    localparam int PAD = 1 << tmr_pkg::CHAN_W;

    tmr_pkg::item_t     item_reg;
    logic               item_valid_reg;
    logic               item_valid_next;
    tmr_pkg::result_t   result_reg;
    tmr_pkg::result_t   result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic               fire;
    logic               addr_ok;
    logic               is_tick;
    logic               is_reload;
    logic               is_ctrl;
    logic               is_read;

    tmr_pkg::chan_cmd_t                cmds   [NUM_CHANNELS];
    logic [tmr_pkg::COUNT_W-1:0]       counts [NUM_CHANNELS];
    logic [tmr_pkg::COUNT_W-1:0]       count_pad [PAD];
    logic [NUM_CHANNELS:0]             carry;
    logic [NUM_CHANNELS-1:0]           irqs;
    logic [tmr_pkg::IRQ_W-1:0]         irq_bits;

    assign fire       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || fire;
    assign addr_ok    = (32'(item_reg.channel) < NUM_CHANNELS);

    always_comb
    begin
        is_tick   = 1'b0;
        is_reload = 1'b0;
        is_ctrl   = 1'b0;
        is_read   = 1'b0;
        unique case (item_reg.kind)
            tmr_pkg::KIND_TICK:   is_tick   = 1'b1;
            tmr_pkg::KIND_RELOAD: is_reload = 1'b1;
            tmr_pkg::KIND_CTRL:   is_ctrl   = 1'b1;
            tmr_pkg::KIND_READ:   is_read   = 1'b1;
            default:              is_tick   = 1'b0;
        endcase
    end

    assign carry[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < NUM_CHANNELS; i++)
        begin : g_chan
            logic sel;
            assign sel = addr_ok && (32'(item_reg.channel) == i);
            assign cmds[i].tick         = fire && is_tick;
            assign cmds[i].write_reload = fire && is_reload && sel;
            assign cmds[i].write_ctrl   = fire && is_ctrl && sel;
            assign cmds[i].value        = item_reg.value;

            tmr_channel u_chan (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmds[i]),
                .carry_in  (carry[i]),
                .count     (counts[i]),
                .carry_out (carry[i+1]),
                .irq       (irqs[i])
            );
        end

        for (i = 0; i < PAD; i++)
        begin : g_pad
            if (i < NUM_CHANNELS)
            begin : g_live
                assign count_pad[i] = counts[i];
            end
            else
            begin : g_none
                assign count_pad[i] = '0;
            end
        end

        for (i = 0; i < tmr_pkg::IRQ_W; i++)
        begin : g_irq
            if (i < NUM_CHANNELS)
            begin : g_live
                assign irq_bits[i] = irqs[i];
            end
            else
            begin : g_none
                assign irq_bits[i] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        result_next           = result_reg;
        result_valid_next     = result_valid_reg;
        if (fire)
        begin
            result_next.read_data = (is_read && addr_ok) ? count_pad[item_reg.channel] : '0;
            result_next.irq_flags = is_tick ? irq_bits : '0;
            result_valid_next     = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        item_valid_next = item_ready ? item_valid : item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_PROP(a_fire_gives_result, clk, rst_n, fire |=> result_valid_reg)
    `ASSERT_PROP(a_irq_only_on_tick, clk, rst_n, (fire && !is_tick) |=> (result_reg.irq_flags == '0))
    `ASSERT_PROP(a_data_only_on_read, clk, rst_n, (fire && !is_read) |=> (result_reg.read_data == '0))

endmodule

[src/tmr_channel.sv]
// One timer channel: settings, prescaler, 16-bit counter and overflow carry.
`include "assert_macros.svh"

module tmr_channel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tmr_pkg::chan_cmd_t          cmd,
    input  logic                        carry_in,
    output logic [tmr_pkg::COUNT_W-1:0] count,
    output logic                        carry_out,
    output logic                        irq
);

    logic [tmr_pkg::COUNT_W-1:0]    count_reg;
    logic [tmr_pkg::COUNT_W-1:0]    count_next;
    logic [tmr_pkg::COUNT_W-1:0]    reload_reg;
    logic [tmr_pkg::COUNT_W-1:0]    reload_next;
    tmr_pkg::prescale_t             prescale_reg;
    tmr_pkg::prescale_t             prescale_next;
    logic                           cascade_reg;
    logic                           cascade_next;
    logic                           irq_en_reg;
    logic                           irq_en_next;
    logic                           running_reg;
    logic                           running_next;
    logic [tmr_pkg::PRESCALE_W-1:0] pcount_reg;
    logic [tmr_pkg::PRESCALE_W-1:0] pcount_next;

    logic                           prescale_hit;
    logic                           step;
    logic                           at_max;
    logic                           over;
    logic                           turn_on;

    assign prescale_hit = (pcount_reg >= tmr_pkg::prescale_limit(prescale_reg));
    assign step         = cmd.tick && running_reg
                        && (cascade_reg ? carry_in : prescale_hit);
    assign at_max       = (count_reg == tmr_pkg::COUNT_MAX);
    assign over         = step && at_max;
    assign turn_on      = cmd.write_ctrl && cmd.value[tmr_pkg::CTRL_ENABLE_BIT]
                        && !running_reg;

    always_comb
    begin
        reload_next   = reload_reg;
        prescale_next = prescale_reg;
        cascade_next  = cascade_reg;
        irq_en_next   = irq_en_reg;
        running_next  = running_reg;
        count_next    = count_reg;
        pcount_next   = pcount_reg;

        if (cmd.write_reload)
        begin
            reload_next = cmd.value;
        end

        if (cmd.write_ctrl)
        begin
            prescale_next = tmr_pkg::prescale_t'(cmd.value[1:0]);
            cascade_next  = cmd.value[tmr_pkg::CTRL_CASCADE_BIT];
            irq_en_next   = cmd.value[tmr_pkg::CTRL_IRQ_BIT];
            running_next  = cmd.value[tmr_pkg::CTRL_ENABLE_BIT];
        end

        if (turn_on)
        begin
            count_next  = reload_reg;
            pcount_next = '0;
        end

        if (cmd.tick && running_reg && !cascade_reg)
        begin
            pcount_next = prescale_hit ? '0 : pcount_reg + 1'b1;
        end

        if (step)
        begin
            count_next = at_max ? reload_reg : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reload_reg   <= '0;
            prescale_reg <= tmr_pkg::PRESCALE_1;
            cascade_reg  <= 1'b0;
            irq_en_reg   <= 1'b0;
            running_reg  <= 1'b0;
            pcount_reg   <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            reload_reg   <= reload_next;
            prescale_reg <= prescale_next;
            cascade_reg  <= cascade_next;
            irq_en_reg   <= irq_en_next;
            running_reg  <= running_next;
            pcount_reg   <= pcount_next;
        end
    end

    assign count     = count_reg;
    assign carry_out = over;
    assign irq       = over && irq_en_reg;

    `ASSERT_PROP(a_overflow_reloads, clk, rst_n, over |=> (count_reg == $past(reload_reg)))
    `ASSERT_PROP(a_stopped_holds, clk, rst_n, (!running_reg && !cmd.write_ctrl) |=> $stable(count_reg))
    `ASSERT_PROP(a_turn_on_loads, clk, rst_n, turn_on |=> (pcount_reg == '0 && count_reg == $past(reload_reg)))

endmodule

[tb/cascadable_four_channel_timer_test.sv]
// Self-checking testbench of the cascadable four-channel timer, with directed and random transactions.
`timescale 1ns / 1ps

module cascadable_four_channel_timer_test;
    import tmr_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    logic [COUNT_W-1:0]    timer_count     [4];
    logic [COUNT_W-1:0]    timer_reload    [4];
    prescale_t             timer_prescale  [4];
    logic                  timer_cascade   [4];
    logic                  timer_irq_en    [4];
    logic                  timer_running   [4];
    logic [PRESCALE_W-1:0] timer_divider   [4];

    result_t expected_results [$];
    result_t oldest_expected;
    int      mismatch_count;
    int      items_sent;
    bit      quiet_tail;

    cascadable_four_channel_timer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic item_t make_item(input kind_t kind, input int chan, input int value);
        item_t it;
        it.kind    = kind;
        it.channel = chan[CHAN_W-1:0];
        it.value   = value[COUNT_W-1:0];
        return it;
    endfunction

    function automatic logic [PRESCALE_W-1:0] divider_limit(input prescale_t sel);
        logic [PRESCALE_W:0] span;
        if (sel == PRESCALE_1)
        begin
            return '0;
        end
        span = 11'd1 << (2 * int'(sel) + 4);
        return PRESCALE_W'(span - 1'b1);
    endfunction

    task automatic predict_timer_result(input item_t it, output result_t r);
        logic carry;
        logic step;
        logic over;
        int   ch;
        ch = int'(it.channel);
        r  = '0;
        case (it.kind)
            KIND_TICK:
            begin
                carry = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    step = 1'b0;
                    over = 1'b0;
                    if (timer_running[i])
                    begin
                        if (timer_cascade[i])
                        begin
                            step = carry;
                        end
                        else if (timer_divider[i] >= divider_limit(timer_prescale[i]))
                        begin
                            timer_divider[i] = '0;
                            step = 1'b1;
                        end
                        else
                        begin
                            timer_divider[i] = timer_divider[i] + 1'b1;
                        end
                    end
                    if (step)
                    begin
                        if (timer_count[i] == COUNT_MAX)
                        begin
                            timer_count[i] = timer_reload[i];
                            over = 1'b1;
                            if (timer_irq_en[i])
                            begin
                                r.irq_flags[i] = 1'b1;
                            end
                        end
                        else
                        begin
                            timer_count[i] = timer_count[i] + 1'b1;
                        end
                    end
                    carry = over;
                end
            end
            KIND_RELOAD:
            begin
                timer_reload[ch] = it.value;
            end
            KIND_CTRL:
            begin
                if (it.value[CTRL_ENABLE_BIT] && !timer_running[ch])
                begin
                    timer_count[ch]   = timer_reload[ch];
                    timer_divider[ch] = '0;
                end
                timer_prescale[ch] = prescale_t'(it.value[1:0]);
                timer_cascade[ch]  = it.value[CTRL_CASCADE_BIT];
                timer_irq_en[ch]   = it.value[CTRL_IRQ_BIT];
                timer_running[ch]  = it.value[CTRL_ENABLE_BIT];
            end
            default:
            begin
                r.read_data = timer_count[ch];
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 200)
        begin
            $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
        end
    endtask

    task automatic send_item(input item_t it);
        result_t want;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predict_timer_result(it, want);
        expected_results.push_back(want);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_item();
        send_item(make_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 3),
                            $urandom_range(0, 65535)));
    endtask

    task automatic run_random_sequence();
        int               ch;
        int               sel;
        logic [COUNT_W-1:0] ctrl;
        ch = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 3)
        begin
            repeat ($urandom_range(1, 6)) send_random_item();
            return;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            send_item(make_item(KIND_RELOAD, ch, 16'hFFFF - $urandom_range(0, 48)));
        end
        else
        begin
            send_item(make_item(KIND_RELOAD, ch, $urandom_range(0, 65535)));
        end
        sel  = $urandom_range(0, 9);
        ctrl = $urandom_range(0, 65535);
        ctrl[1:0] = (sel < 7) ? PRESCALE_1 : (sel < 9) ? PRESCALE_64 : 2'($urandom_range(2, 3));
        ctrl[CTRL_CASCADE_BIT] = ($urandom_range(0, 2) == 0);
        ctrl[CTRL_ENABLE_BIT]  = ($urandom_range(0, 6) != 0);
        send_item(make_item(KIND_CTRL, ch, ctrl));
        repeat ($urandom_range(1, 40))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(make_item(KIND_READ, $urandom_range(0, 3), $urandom_range(0, 65535)));
            end
            else
            begin
                send_item(make_item(KIND_TICK, $urandom_range(0, 3), $urandom_range(0, 65535)));
            end
        end
    endtask

    task automatic test_directed_basics();
        send_item(make_item(KIND_READ, 0, 16'h0000));
        send_item(make_item(KIND_READ, 3, 16'hFFFF));
        send_item(make_item(KIND_TICK, 3, 16'hFFFF));
        send_item(make_item(KIND_RELOAD, 0, 16'hFFFF));
        send_item(make_item(KIND_CTRL, 0, 16'h00C0));
        send_item(make_item(KIND_READ, 0, 16'h0000));
        send_item(make_item(KIND_RELOAD, 1, 16'hFFFF));
        send_item(make_item(KIND_CTRL, 1, 16'hFFFF));
        send_item(make_item(KIND_RELOAD, 2, 16'h0000));
        send_item(make_item(KIND_CTRL, 2, 16'h00C4));
        send_item(make_item(KIND_TICK, 0, 16'h0000));
        send_item(make_item(KIND_READ, 2, 16'h0000));
        send_item(make_item(KIND_CTRL, 0, 16'h00C4));
        send_item(make_item(KIND_TICK, 1, 16'h5A5A));
        send_item(make_item(KIND_READ, 0, 16'h0000));
        send_item(make_item(KIND_CTRL, 2, 16'h0000));
        send_item(make_item(KIND_READ, 2, 16'h0000));
        send_item(make_item(KIND_RELOAD, 0, 16'h1234));
        send_item(make_item(KIND_READ, 0, 16'h0000));
        send_item(make_item(KIND_RELOAD, 3, 16'hFFFF));
        send_item(make_item(KIND_CTRL, 3, 16'hFF43));
        send_item(make_item(KIND_CTRL, 3, 16'h00C0));
        send_item(make_item(KIND_TICK, 2, 16'hA5A5));
        send_item(make_item(KIND_READ, 3, 16'h0000));
    endtask

    task automatic test_prescale_divisors();
        for (int ch = 0; ch < 4; ch++)
        begin
            send_item(make_item(KIND_CTRL, ch, 16'h0000));
        end
        send_item(make_item(KIND_RELOAD, 0, 16'hFFFF));
        send_item(make_item(KIND_CTRL, 0, 16'h00C3));
        send_item(make_item(KIND_RELOAD, 1, 16'hFFFC));
        send_item(make_item(KIND_CTRL, 1, 16'h00C2));
        send_item(make_item(KIND_RELOAD, 2, 16'hFFE0));
        send_item(make_item(KIND_CTRL, 2, 16'h00C1));
        send_item(make_item(KIND_RELOAD, 3, 16'hFFFE));
        send_item(make_item(KIND_CTRL, 3, 16'h00C4));
        for (int n = 0; n < 280; n++)
        begin
            if (n % 31 == 0)
            begin
                send_item(make_item(KIND_READ, n % 4, 16'h0000));
            end
            send_item(make_item(KIND_TICK, 0, 16'h0000));
        end
        send_item(make_item(KIND_CTRL, 0, 16'h00C1));
        send_item(make_item(KIND_CTRL, 1, 16'h00C0));
        for (int n = 0; n < 100; n++)
        begin
            if (n % 31 == 0)
            begin
                send_item(make_item(KIND_READ, n % 4, 16'h0000));
            end
            send_item(make_item(KIND_TICK, 0, 16'h0000));
        end
    endtask

    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent - start < 200)
        begin
            run_random_sequence();
        end
    endtask

    task automatic test_drain_pause();
        repeat (10) send_random_item();
        wait_for_drain();
        repeat (10) send_random_item();
    endtask

    task automatic test_quiet_tail();
        int start;
        quiet_tail = 1'b1;
        start = items_sent;
        while (items_sent - start < 40)
        begin
            run_random_sequence();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        mismatch_count = 0;
        items_sent   = 0;
        quiet_tail   = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            timer_count[i]    = '0;
            timer_reload[i]   = '0;
            timer_prescale[i] = PRESCALE_1;
            timer_cascade[i]  = 1'b0;
            timer_irq_en[i]   = 1'b0;
            timer_running[i]  = 1'b0;
            timer_divider[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_prescale_divisors();
        test_random_traffic();
        test_drain_pause();
        test_quiet_tail();
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result transaction", 16'h0000, result.read_data);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.read_data !== oldest_expected.read_data)
                begin
                    report_mismatch("read_data", oldest_expected.read_data, result.read_data);
                end
                if (result.irq_flags !== oldest_expected.irq_flags)
                begin
                    report_mismatch("irq_flags", 16'(oldest_expected.irq_flags),
                                    16'(result.irq_flags));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
